[hdl/rte_pkg.sv]
package rte_pkg;

   localparam int CHUNK_BITS   = 2;
   localparam int CODE_BITS    = 4;
   localparam int MAX_CHUNKS   = 8;
   localparam int KEY_W        = CHUNK_BITS * MAX_CHUNKS;
   localparam int ENTRY_W      = CODE_BITS * MAX_CHUNKS;
   localparam int COUNT_W      = 4;
   localparam int POS_W        = $clog2(MAX_CHUNKS);
   localparam int RESULT_LIMIT = 32;
   localparam int RESULT_W     = $clog2(RESULT_LIMIT);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam logic [COUNT_W-1:0] CHUNK_COUNT_RESET = COUNT_W'(MAX_CHUNKS);

   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [ENTRY_W-1:0]    entry_type;
   typedef logic [COUNT_W-1:0]    chunk_count_type;
   typedef logic [CHUNK_BITS-1:0] chunk_type;

   // One entry to be formatted: the low bound supplies the exact chunks above
   // the split chunk, and the chunk pair at the split selects the table row.
   typedef struct packed {
      key_type              low_key;
      logic [POS_W-1:0]     split_pos;
      chunk_type            split_low;
      chunk_type            split_high;
      logic                 last;
   } token_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_RUN
   } front_state_type;

   function automatic logic [CODE_BITS-1:0] code_lookup(input logic [3:0] idx);
      logic [CODE_BITS-1:0] res;
      case (idx)
         4'h5:    res = 4'hC;
         4'h6:    res = 4'h8;
         4'h7:    res = 4'h8;
         4'hA:    res = 4'hA;
         4'hB:    res = 4'h8;
         4'hF:    res = 4'h9;
         default: res = 4'h0;
      endcase
      return res;
   endfunction

   function automatic logic [CODE_BITS-1:0] mask_lookup(input logic [3:0] idx);
      logic [CODE_BITS-1:0] res;
      case (idx)
         4'h1:    res = 4'h3;
         4'h2:    res = 4'h1;
         4'h3:    res = 4'h0;
         4'h6:    res = 4'h9;
         4'h7:    res = 4'h8;
         4'hB:    res = 4'hC;
         default: res = 4'hF;
      endcase
      return res;
   endfunction

endpackage

[hdl/range_to_ternary_entry_encoder.sv]
// Channel   Ports                                    Handshake
// request   start, busy, req_range_low/high          taken when start and not busy
// response  rsp_strobe, rsp_entry_code/mask/last     one-cycle strobe per entry, no stall
// config    csr_we, csr_wdata                        written when csr_we is high
//
// The stack walk handles one subrange per clock cycle.
// The formatter drains the four-slot entry queue every cycle, so it never fills.
// Busy stays high until the cycle in which the last entry is on the response ports.
// Synchronous reset returns the chunk count to eight and the block to idle.
module range_to_ternary_entry_encoder #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  rte_pkg::key_type         req_range_low,
   input  rte_pkg::key_type         req_range_high,
   output logic                     rsp_strobe,
   output rte_pkg::entry_type       rsp_entry_code,
   output rte_pkg::entry_type       rsp_entry_mask,
   output logic                     rsp_last_entry,
   input  logic                     csr_we,
   input  rte_pkg::chunk_count_type csr_wdata
);

   rte_pkg::chunk_count_type chunk_count_ff, chunk_count_in;
   rte_pkg::chunk_count_type chunk_n;
   logic                     busy_ff, busy_in;
   logic                     accept;
   logic                     front_valid;
   rte_pkg::token_type       front_token;
   logic                     queue_full;
   logic                     back_valid;
   rte_pkg::token_type       back_token;
   logic                     back_done;

   assign accept = start && !busy_ff;

   always_comb begin
      chunk_count_in = csr_we ? csr_wdata : chunk_count_ff;
      if (chunk_count_ff == '0) begin
         chunk_n = rte_pkg::COUNT_W'(1);
      end else if (chunk_count_ff > rte_pkg::COUNT_W'(rte_pkg::MAX_CHUNKS)) begin
         chunk_n = rte_pkg::COUNT_W'(rte_pkg::MAX_CHUNKS);
      end else begin
         chunk_n = chunk_count_ff;
      end
      busy_in = accept ? 1'b1 : (back_done ? 1'b0 : busy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= rte_pkg::CHUNK_COUNT_RESET;
         busy_ff        <= 1'b0;
      end else begin
         chunk_count_ff <= chunk_count_in;
         busy_ff        <= busy_in;
      end
   end

   assign busy = busy_ff;

   rte_front #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .range_low   (req_range_low),
      .range_high  (req_range_high),
      .chunk_n     (chunk_n),
      .queue_full  (queue_full),
      .token_valid (front_valid),
      .token       (front_token)
   );

   rte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_token (front_token),
      .full       (queue_full),
      .pop_valid  (back_valid),
      .pop_token  (back_token)
   );

   rte_back u_back (
      .clock          (clock),
      .reset          (reset),
      .token_valid    (back_valid),
      .token          (back_token),
      .chunk_n        (chunk_n),
      .done           (back_done),
      .rsp_strobe     (rsp_strobe),
      .rsp_entry_code (rsp_entry_code),
      .rsp_entry_mask (rsp_entry_mask),
      .rsp_last_entry (rsp_last_entry)
   );

endmodule

[hdl/rte_queue.sv]
module rte_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  rte_pkg::token_type push_token,
   output logic               full,
   output logic               pop_valid,
   output rte_pkg::token_type pop_token
);

   localparam int AW = rte_pkg::QUEUE_AW;

   rte_pkg::token_type slot_ff [rte_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          do_push;
   logic          do_pop;

   // The formatter never stalls, so the head leaves whenever it is present.
   assign full      = (fill_ff == (AW+1)'(rte_pkg::QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_token = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

[hdl/rte_front.sv]
module rte_front #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  rte_pkg::key_type         range_low,
   input  rte_pkg::key_type         range_high,
   input  rte_pkg::chunk_count_type chunk_n,
   input  logic                     queue_full,
   output logic                     token_valid,
   output rte_pkg::token_type       token
);

   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int KW = rte_pkg::KEY_W;
   localparam int PW = rte_pkg::POS_W;
   localparam int RW = rte_pkg::RESULT_W;

   // Stack entries below the range in hand; the range in hand is the top.
   logic [2*KW-1:0] stack_mem [STACK_DEPTH];
   logic [2*KW-1:0] rd_data_ff;

   rte_pkg::front_state_type state_ff, state_in;
   rte_pkg::key_type cur_a_ff, cur_a_in;
   rte_pkg::key_type cur_b_ff, cur_b_in;
   logic             from_mem_ff, from_mem_in;
   logic [SW-1:0]    sp_ff, sp_in;
   logic [RW-1:0]    count_ff, count_in;

   rte_pkg::key_type key_mask;
   rte_pkg::key_type key_a, key_b, diff;
   logic [PW-1:0]    pos;
   logic [4:0]       off;
   rte_pkg::key_type low_bits, pre_a, pre_b;
   logic [KW:0]      upper_mask;
   rte_pkg::chunk_type va, vb, ms, me;
   logic             wide, adjacent, start_full, end_full;
   rte_pkg::key_type x_lo, x_hi, y_lo, y_hi, edge_key;
   logic             two_push, one_push, emit, finish, step;
   logic [SW-1:0]    wr_idx, rd_idx;
   logic             mem_we, mem_re;

   always_comb begin
      for (int q = 0; q < rte_pkg::MAX_CHUNKS; q++) begin
         key_mask[2*q +: 2] = (rte_pkg::COUNT_W'(q) < chunk_n) ? 2'b11 : 2'b00;
      end
   end

   assign key_a = from_mem_ff ? rd_data_ff[2*KW-1:KW] : cur_a_ff;
   assign key_b = from_mem_ff ? rd_data_ff[KW-1:0] : cur_b_ff;
   assign diff  = key_a ^ key_b;

   // The highest differing chunk is the split; equal bounds split at the
   // lowest chunk.
   always_comb begin
      pos = '0;
      for (int q = 0; q < rte_pkg::MAX_CHUNKS; q++) begin
         if (diff[2*q +: 2] != 2'b00) begin
            pos = PW'(q);
         end
      end
   end

   always_comb begin
      off        = 5'({pos, 1'b0});
      low_bits   = KW'((17'd1 << off) - 17'd1);
      upper_mask = (17'd1 << (off + 5'd2)) - 17'd1;
      pre_a      = key_a & ~upper_mask[KW-1:0];
      pre_b      = key_b & ~upper_mask[KW-1:0];
      va         = 2'(key_a >> off);
      vb         = 2'(key_b >> off);
      wide       = ({1'b0, vb} >= ({1'b0, va} + 3'd2));
      adjacent   = ({1'b0, vb} == ({1'b0, va} + 3'd1));
      start_full = ((key_a & low_bits) == '0);
      end_full   = ((key_b & low_bits) == low_bits);
      ms         = start_full ? va : va + 2'd1;
      me         = end_full ? vb : vb - 2'd1;
      edge_key   = pre_a | (KW'(va + 2'd1) << off);

      // X is pushed first, Y second, so Y is expanded first.
      if (adjacent) begin
         x_lo = edge_key;
         x_hi = key_b;
         y_lo = key_a;
         y_hi = edge_key - KW'(1);
      end else begin
         x_lo = pre_b | (KW'(me + 2'd1) << off);
         x_hi = key_b;
         y_lo = key_a;
         y_hi = (pre_a | (KW'(ms) << off)) - KW'(1);
      end

      two_push = adjacent || (wide && !start_full && !end_full);
      one_push = wide && (start_full != end_full);
      emit     = !adjacent;
   end

   assign step   = (state_ff == rte_pkg::FRONT_RUN) && !queue_full;
   assign finish = emit && ((!two_push && !one_push && sp_ff == SW'(1)) ||
                            count_ff == RW'(rte_pkg::RESULT_LIMIT - 1));
   assign wr_idx = sp_ff - SW'(1);
   assign rd_idx = sp_ff - SW'(2);
   assign mem_we = step && two_push && (sp_ff < SW'(STACK_DEPTH));
   assign mem_re = step && !two_push && !one_push;

   always_comb begin
      state_in    = state_ff;
      cur_a_in    = cur_a_ff;
      cur_b_in    = cur_b_ff;
      from_mem_in = from_mem_ff;
      sp_in       = sp_ff;
      count_in    = count_ff;
      case (state_ff)
         rte_pkg::FRONT_IDLE: begin
            if (accept) begin
               state_in    = rte_pkg::FRONT_RUN;
               cur_a_in    = range_low & key_mask;
               cur_b_in    = range_high & key_mask;
               from_mem_in = 1'b0;
               sp_in       = SW'(1);
               count_in    = '0;
            end
         end
         rte_pkg::FRONT_RUN: begin
            if (step) begin
               if (emit) begin
                  count_in = count_ff + RW'(1);
               end
               if (two_push) begin
                  from_mem_in = 1'b0;
                  if (sp_ff < SW'(STACK_DEPTH)) begin
                     cur_a_in = y_lo;
                     cur_b_in = y_hi;
                     sp_in    = sp_ff + SW'(1);
                  end else begin
                     cur_a_in = x_lo;
                     cur_b_in = x_hi;
                  end
               end else if (one_push) begin
                  from_mem_in = 1'b0;
                  cur_a_in    = end_full ? y_lo : x_lo;
                  cur_b_in    = end_full ? y_hi : x_hi;
               end else begin
                  from_mem_in = 1'b1;
                  sp_in       = sp_ff - SW'(1);
               end
               if (finish) begin
                  state_in = rte_pkg::FRONT_IDLE;
               end
            end
         end
         default: begin
            state_in = rte_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rte_pkg::FRONT_IDLE;
         from_mem_ff <= 1'b0;
         sp_ff       <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         from_mem_ff <= from_mem_in;
         sp_ff       <= sp_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_a_ff <= cur_a_in;
      cur_b_ff <= cur_b_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx[AW-1:0]] <= {x_lo, x_hi};
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_idx[AW-1:0]];
      end
   end

   assign token_valid      = step && emit;
   assign token.low_key    = key_a;
   assign token.split_pos  = pos;
   assign token.split_low  = wide ? ms : va;
   assign token.split_high = wide ? me : vb;
   assign token.last       = finish;

endmodule

[hdl/rte_back.sv]
module rte_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     token_valid,
   input  rte_pkg::token_type       token,
   input  rte_pkg::chunk_count_type chunk_n,
   output logic                     done,
   output logic                     rsp_strobe,
   output rte_pkg::entry_type       rsp_entry_code,
   output rte_pkg::entry_type       rsp_entry_mask,
   output logic                     rsp_last_entry
);

   localparam int CB = rte_pkg::CODE_BITS;

   logic               strobe_ff;
   rte_pkg::entry_type code_ff, code_in;
   rte_pkg::entry_type mask_ff, mask_in;
   logic               last_ff;

   // Chunks above the split match exactly, the split chunk uses the pair
   // from the tables, and chunks below it or past the chunk count are wildcards.
   always_comb begin
      logic [3:0]         idx;
      rte_pkg::chunk_type v;
      for (int q = 0; q < rte_pkg::MAX_CHUNKS; q++) begin
         v   = token.low_key[2*q +: 2];
         idx = {token.split_low, token.split_high};
         if (rte_pkg::COUNT_W'(q) >= chunk_n) begin
            code_in[CB*q +: CB] = '0;
            mask_in[CB*q +: CB] = '0;
         end else if (rte_pkg::POS_W'(q) > token.split_pos) begin
            code_in[CB*q +: CB] = rte_pkg::code_lookup({v, v});
            mask_in[CB*q +: CB] = rte_pkg::mask_lookup({v, v});
         end else if (rte_pkg::POS_W'(q) == token.split_pos) begin
            code_in[CB*q +: CB] = rte_pkg::code_lookup(idx);
            mask_in[CB*q +: CB] = rte_pkg::mask_lookup(idx);
         end else begin
            code_in[CB*q +: CB] = '0;
            mask_in[CB*q +: CB] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= token_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (token_valid) begin
         code_ff <= code_in;
         mask_ff <= mask_in;
         last_ff <= token.last;
      end
   end

   assign done           = token_valid && token.last;
   assign rsp_strobe     = strobe_ff;
   assign rsp_entry_code = code_ff;
   assign rsp_entry_mask = mask_ff;
   assign rsp_last_entry = last_ff;

endmodule

[hdl/rte_checker.sv]
module rte_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_entry
);

   // Entries only come out of a request in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("entry shown without a request in progress");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // Busy drops exactly as the final entry of a request appears.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_last_entry)
      else $error("busy fell without a final entry");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !busy |-> rsp_last_entry)
      else $error("non-final entry shown while idle");

endmodule

bind range_to_ternary_entry_encoder rte_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_last_entry (rsp_last_entry)
);
